@@ design/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers used by the top rtl file
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/rps_pkg.sv @@
// ------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the range partition splitter
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package rps_pkg;

	localparam int NUM_PARTS_DEF = 16;
	localparam logic [31:0] CLAMP_RESET = 32'hFFFF_FFFF;
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic REG_CLAMP = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FIRST,
		ST_SCAN,
		ST_WALK
	} rps_state_t;

endpackage

@@ design/rps_ram.sv @@
// ------------------------------------------------------------------------
// rps_ram
// generic single write port ram with registered read
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module rps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/range_partition_splitter_top.sv @@
// sequencing: a load is written to the table from idle without going busy; a query
// steps through ST_CHECK, ST_FIRST and ST_SCAN, then ST_WALK while pieces follow,
// over at most NUM_PARTS fences, its last piece marked by last_piece; an empty range returns to idle from ST_CHECK
// throughput: one fence per cycle through the single read port of the table,
// pieces leave one per cycle on result_valid, the receiver cannot stall
// reset: arst_n clears the sequencer and sets clamp_q to all ones
`timescale 1ns / 1ps

// ------------------------------------------------------------------------
// range_partition_splitter_top
// splits a half-open range at loaded partition fences, one piece per cycle
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module range_partition_splitter_top import rps_pkg::*; #(
	parameter int NUM_PARTS = NUM_PARTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [4:0]  fence_slot,
	input  logic [31:0] fence_value,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	output logic        result_valid,
	output logic [3:0]  part_index,
	output logic [31:0] offset_in_range,
	output logic [31:0] offset_in_part,
	output logic [31:0] overlap_count,
	output logic        last_piece
);

	localparam int AW = $clog2(NUM_PARTS + 1);

	rps_state_t state_q, state_n;
	logic [AW-1:0] p_q, p_n;
	logic [31:0] clamp_q, s_q, e_q, fcur_q, fcur_n;
	logic [AW-1:0] raddr;
	logic [31:0] rdata;
	logic ram_we;
	logic emit, emit_last;
	logic [31:0] lo, hi, cnt;
	logic last_p, next_in;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CLAMP) ? clamp_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= CLAMP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLAMP) begin
			clamp_q <= pwdata;
		end
	end

	// fence table
	assign busy = (state_q != ST_IDLE);
	assign ram_we = start && !busy && req_type == REQ_LOAD
		&& 32'(fence_slot) <= 32'(NUM_PARTS);

	rps_ram #(
		.WIDTH(32),
		.DEPTH(NUM_PARTS + 1)
	) u_fence_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(fence_slot)),
		.wdata(fence_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// piece arithmetic, fcur_q holds the partition start, rdata its end
	assign lo      = (s_q > fcur_q) ? s_q : fcur_q;
	assign hi      = (e_q < rdata) ? e_q : rdata;
	assign cnt     = (hi > lo) ? hi - lo : 32'd0;
	assign last_p  = (p_q == AW'(NUM_PARTS - 1));
	assign next_in = (rdata < e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
		end else begin
			state_q <= state_n;
			p_q     <= p_n;
		end
	end

	always_ff @(posedge clk) begin
		fcur_q <= fcur_n;
		if (start && !busy && req_type == REQ_QUERY) begin
			s_q <= (range_start < clamp_q) ? range_start : clamp_q;
			e_q <= (range_end < clamp_q) ? range_end : clamp_q;
		end
	end

	always_comb begin
		state_n   = state_q;
		p_n       = p_q;
		fcur_n    = fcur_q;
		raddr     = '0;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && req_type == REQ_QUERY) begin
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				p_n = '0;
				if (e_q <= s_q) begin
					state_n = ST_IDLE;
				end else begin
					state_n = ST_FIRST;
				end
			end
			ST_FIRST: begin
				fcur_n  = rdata;
				raddr   = AW'(1);
				state_n = ST_SCAN;
			end
			ST_SCAN: begin
				if (rdata <= s_q) begin
					if (last_p) begin
						state_n = ST_IDLE;
					end else begin
						fcur_n = rdata;
						p_n    = p_q + AW'(1);
						raddr  = AW'(p_q + AW'(2));
					end
				end else if (!(fcur_q < e_q)) begin
					state_n = ST_IDLE;
				end else begin
					emit      = 1'b1;
					emit_last = last_p || !next_in;
					if (emit_last) begin
						state_n = ST_IDLE;
					end else begin
						fcur_n  = rdata;
						p_n     = p_q + AW'(1);
						raddr   = AW'(p_q + AW'(2));
						state_n = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				emit      = 1'b1;
				emit_last = last_p || !next_in;
				if (emit_last) begin
					state_n = ST_IDLE;
				end else begin
					fcur_n = rdata;
					p_n    = p_q + AW'(1);
					raddr  = AW'(p_q + AW'(2));
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			part_index      <= 4'(p_q);
			offset_in_range <= lo - s_q;
			offset_in_part  <= lo - fcur_q;
			overlap_count   <= cnt;
			last_piece      <= emit_last;
		end
	end

	`ASSERT_IMPL(a_more_pieces_busy, clk, arst_n, result_valid && !last_piece, busy, "piece without last mark while idle")
	`ASSERT_CLK(a_last_ends_run, clk, arst_n, result_valid && last_piece |=> !result_valid, "piece after last piece")
	`ASSERT_CLK(a_query_busy, clk, arst_n, start && !busy && req_type == REQ_QUERY |=> busy, "query accepted but not busy")
	`ASSERT_IMPL(a_emit_in_walk, clk, arst_n, emit, state_q == ST_SCAN || state_q == ST_WALK, "piece outside walk")

endmodule
